// File: hdl/ptwa_pkg.sv
// Shared types and constants for the peer table with aging.
`default_nettype none
package ptwa_pkg;

	localparam int PEER_SLOTS = 64;
	localparam int ADDR_W     = 16;
	localparam int TIME_W     = 32;
	localparam int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int CNT_W      = SLOT_W + 1;
	localparam int SLOT_OUT_W = 6;
	localparam int KIND_W     = 3;
	localparam logic [TIME_W-1:0] EXPIRE_RESET = TIME_W'(600);

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [TIME_W-1:0]     time_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [SLOT_OUT_W-1:0] slot_out_t;

	typedef enum logic [KIND_W-1:0] {
		EV_REFRESHED  = 3'd0,
		EV_ADDED      = 3'd1,
		EV_FULL       = 3'd2,
		EV_IGNORED    = 3'd3,
		EV_EXPIRED    = 3'd4,
		EV_SWEEP_NONE = 3'd5
	} ev_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL
	} state_t;

	// Table access from the sequencer.
	typedef struct packed {
		logic  rd_en;
		slot_t rd_idx;
		logic  wr_en;
		slot_t wr_idx;
		addr_t wr_addr;
		time_t wr_time;
		logic  clr_en;
		slot_t clr_idx;
	} tbl_req_t;

	// Registered read data of one slot.
	typedef struct packed {
		logic  vld;
		addr_t addr;
		time_t seen;
	} tbl_rsp_t;

	// One result handed to the output register.
	typedef struct packed {
		logic      valid;
		ev_kind_t  kind;
		addr_t     addr;
		slot_out_t slot;
		logic      last;
	} emit_t;

endpackage
`default_nettype wire

// File: hdl/peer_table_with_aging.sv
// Peer table with aging: reads one slot a cycle through a registered memory port,
// as long as the output does not stall. A refresh of slot i ends the scan there; an add,
// a table-full result or a sweep scans all PEER_SLOTS slots.
// One transaction is worked at a time; s_axis_tready is high only while idle.
// Reset clears all slot valid bits at once and loads the expiry limit with 600.
`default_nettype none
module peer_table_with_aging (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // peer_address[15:0], now_seconds[47:16]
	input  wire logic [0:0]  s_axis_tuser,  // req_type[0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // event_address[15:0], slot_index[21:16], zero
	output logic [2:0]       m_axis_tuser,  // event_kind[2:0]
	output logic             m_axis_tlast,  // last_result
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data       // expire_seconds
);
	import ptwa_pkg::*;

	time_t    expire_q;
	tbl_req_t tbl_req;
	tbl_rsp_t tbl_rsp;
	emit_t    emit;
	logic     out_free;

	logic      m_valid_q;
	ev_kind_t  m_kind_q;
	addr_t     m_addr_q;
	slot_out_t m_slot_q;
	logic      m_last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expire_q <= EXPIRE_RESET;
		end else if (cfg_valid) begin
			expire_q <= cfg_data;
		end
	end

	ptwa_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rsp    (tbl_rsp)
	);

	ptwa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_sweep (s_axis_tuser[0]),
		.in_addr  (s_axis_tdata[15:0]),
		.in_now   (s_axis_tdata[47:16]),
		.in_ready (s_axis_tready),
		.expire   (expire_q),
		.tbl_req  (tbl_req),
		.tbl_rsp  (tbl_rsp),
		.out_free (out_free),
		.emit     (emit)
	);

	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_kind_q  <= EV_REFRESHED;
			m_addr_q  <= '0;
			m_slot_q  <= '0;
			m_last_q  <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= emit.valid;
			if (emit.valid) begin
				m_kind_q <= emit.kind;
				m_addr_q <= emit.addr;
				m_slot_q <= emit.slot;
				m_last_q <= emit.last;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_slot_q, m_addr_q};
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;

`ifndef ASSERT_OFF
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !emit.valid)
		else $error("result issued while idle");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.kind == EV_SWEEP_NONE) |-> (emit.last && emit.addr == '0))
		else $error("sweep-none result malformed");

	a_no_rd_on_wr: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.wr_en |-> (!tbl_req.rd_en && !tbl_req.clr_en))
		else $error("table write overlaps scan");

	a_wr_done: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_req.wr_en |=> s_axis_tready)
		else $error("sequencer busy after table write");
`endif

endmodule
`default_nettype wire

// File: hdl/ptwa_table.sv
// Slot storage: address and last-seen memories with per-slot valid bits.
`default_nettype none
module ptwa_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ptwa_pkg::tbl_req_t req,
	output ptwa_pkg::tbl_rsp_t     rsp
);
	import ptwa_pkg::*;

	addr_t addr_mem [PEER_SLOTS];
	time_t time_mem [PEER_SLOTS];
	logic [PEER_SLOTS-1:0] valid_q;

	addr_t rd_addr_s1;
	time_t rd_time_s1;
	logic  rd_vld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			addr_mem[req.wr_idx] <= req.wr_addr;
			time_mem[req.wr_idx] <= req.wr_time;
		end
		if (req.rd_en) begin
			rd_addr_s1 <= addr_mem[req.rd_idx];
			rd_time_s1 <= time_mem[req.rd_idx];
		end
	end

	// A slot that is not valid reads as empty, whatever the memory holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rd_vld_s1 <= valid_q[req.rd_idx];
			end
			if (req.wr_en) begin
				valid_q[req.wr_idx] <= 1'b1;
			end
			if (req.clr_en) begin
				valid_q[req.clr_idx] <= 1'b0;
			end
		end
	end

	assign rsp.vld  = rd_vld_s1;
	assign rsp.addr = rd_vld_s1 ? rd_addr_s1 : '0;
	assign rsp.seen = rd_vld_s1 ? rd_time_s1 : '0;

endmodule
`default_nettype wire

// File: hdl/ptwa_unit.sv
// Shared slot compare unit: address match for lookups, age test for sweeps.
`default_nettype none
module ptwa_unit (
	input  wire logic               sweep,
	input  wire ptwa_pkg::addr_t    key,
	input  wire ptwa_pkg::time_t    now,
	input  wire ptwa_pkg::time_t    expire,
	input  wire ptwa_pkg::tbl_rsp_t rsp,
	output logic                    hit
);
	import ptwa_pkg::*;

	time_t age;

	// Age wraps modulo the time width, as the time stamps do.
	assign age = now - rsp.seen;

	always_comb begin
		if (sweep) begin
			hit = rsp.vld && (age >= expire);
		end else begin
			hit = rsp.vld && (rsp.addr == key);
		end
	end

endmodule
`default_nettype wire

// File: hdl/ptwa_ctrl.sv
// Sequencer: scans a slot per cycle if output is free; issues results.
`default_nettype none
module ptwa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_sweep,
	input  wire ptwa_pkg::addr_t    in_addr,
	input  wire ptwa_pkg::time_t    in_now,
	output logic                    in_ready,
	input  wire ptwa_pkg::time_t    expire,
	output ptwa_pkg::tbl_req_t      tbl_req,
	input  wire ptwa_pkg::tbl_rsp_t tbl_rsp,
	input  wire logic               out_free,
	output ptwa_pkg::emit_t         emit
);
	import ptwa_pkg::*;

	state_t state_q, state_d;
	logic   sweep_q;
	addr_t  key_q;
	time_t  now_q;
	cnt_t   rd_idx_q;
	logic   vld_s1;
	slot_t  idx_s1;
	logic   free_found_q;
	slot_t  free_idx_q;
	logic   pend_q;
	addr_t  pend_addr_q;
	slot_t  pend_idx_q;

	logic hit;
	logic advance;
	logic more;

	ptwa_unit u_unit (
		.sweep  (sweep_q),
		.key    (key_q),
		.now    (now_q),
		.expire (expire),
		.rsp    (tbl_rsp),
		.hit    (hit)
	);

	assign more = (rd_idx_q < cnt_t'(PEER_SLOTS));

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		advance         = 1'b0;
		tbl_req         = '0;
		tbl_req.rd_idx  = rd_idx_q[SLOT_W-1:0];
		tbl_req.wr_addr = key_q;
		tbl_req.wr_time = now_q;
		tbl_req.clr_idx = idx_s1;
		emit            = '0;
		emit.kind       = EV_REFRESHED;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (!in_sweep && in_addr == '0) ? ST_FINAL : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (vld_s1 && hit && !sweep_q) begin
					emit.valid = 1'b1;
					emit.kind  = EV_REFRESHED;
					emit.addr  = key_q;
					emit.slot  = slot_out_t'(idx_s1);
					emit.last  = 1'b1;
					if (out_free) begin
						tbl_req.wr_en  = 1'b1;
						tbl_req.wr_idx = idx_s1;
						state_d        = ST_IDLE;
					end
				end else begin
					// An earlier expiry goes out only once a later one is known,
					// so that the final one can carry the last flag.
					if (vld_s1 && hit && pend_q) begin
						emit.valid = 1'b1;
						emit.kind  = EV_EXPIRED;
						emit.addr  = pend_addr_q;
						emit.slot  = slot_out_t'(pend_idx_q);
						emit.last  = 1'b0;
					end
					advance = !emit.valid || out_free;
					if (advance) begin
						tbl_req.rd_en  = more;
						tbl_req.clr_en = vld_s1 && hit;
					end
					if (!vld_s1 && !more) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_FINAL: begin
				emit.valid = 1'b1;
				emit.last  = 1'b1;
				if (sweep_q) begin
					if (pend_q) begin
						emit.kind = EV_EXPIRED;
						emit.addr = pend_addr_q;
						emit.slot = slot_out_t'(pend_idx_q);
					end else begin
						emit.kind = EV_SWEEP_NONE;
					end
				end else if (key_q == '0) begin
					emit.kind = EV_IGNORED;
				end else if (free_found_q) begin
					emit.kind = EV_ADDED;
					emit.addr = key_q;
					emit.slot = slot_out_t'(free_idx_q);
					if (out_free) begin
						tbl_req.wr_en  = 1'b1;
						tbl_req.wr_idx = free_idx_q;
					end
				end else begin
					emit.kind = EV_FULL;
					emit.addr = key_q;
				end
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b0;
			key_q        <= '0;
			now_q        <= '0;
			rd_idx_q     <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			pend_q       <= 1'b0;
			pend_addr_q  <= '0;
			pend_idx_q   <= '0;
		end else begin
			if (state_q == ST_IDLE && in_valid) begin
				sweep_q      <= in_sweep;
				key_q        <= in_addr;
				now_q        <= in_now;
				rd_idx_q     <= '0;
				vld_s1       <= 1'b0;
				free_found_q <= 1'b0;
				pend_q       <= 1'b0;
			end else if (state_q == ST_SCAN && advance) begin
				vld_s1 <= more;
				idx_s1 <= rd_idx_q[SLOT_W-1:0];
				if (more) begin
					rd_idx_q <= rd_idx_q + cnt_t'(1);
				end
				if (vld_s1 && !sweep_q && !tbl_rsp.vld && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
				if (vld_s1 && sweep_q && hit) begin
					pend_q      <= 1'b1;
					pend_addr_q <= tbl_rsp.addr;
					pend_idx_q  <= idx_s1;
				end
			end
		end
	end

endmodule
`default_nettype wire
